// ----- sv/stx_pkg.sv -----
// Package with constants, the pipeline status type and the swirl wave function.
package stx_pkg;

    localparam int COORD_W   = 6;
    localparam int INDEX_W   = 12;
    localparam int TEXEL_W   = 8;
    localparam int TICK_W    = 8;
    localparam int PHASE_W   = 13;
    localparam int TEXELS    = 4096;
    localparam int QUEUE_DEPTH = 3;

    localparam logic [PHASE_W-1:0] SWIRL_X1 = 13'd900;
    localparam logic [PHASE_W-1:0] SWIRL_X2 = 13'd300;
    localparam logic [PHASE_W-1:0] SWIRL_Y1 = 13'd700;
    localparam logic [PHASE_W-1:0] SWIRL_Y2 = 13'd1200;
    localparam logic [COORD_W-1:0] CENTER_BIAS = 6'd0;  // 128 mod 64

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_RENDER = 1'b1;

    typedef struct packed {
        logic [1:0] count;
        logic       read_pending;
    } queue_status_t;

    // floor(2*sin(2*pi*(k+0.5)/8192)) as a value added modulo 64.
    function automatic logic [COORD_W-1:0] wave(input logic [PHASE_W-1:0] k);
        logic [COORD_W-1:0] w;
        if (k >= 13'd683 && k <= 13'd3412)
            w = 6'd1;
        else if (k < 13'd4096)
            w = 6'd0;
        else if (k <= 13'd4778 || k >= 13'd7509)
            w = 6'd63;
        else
            w = 6'd62;
        return w;
    endfunction

endpackage

// ----- sv/swirl_texture_remap_top.sv -----
// Swirling texture lookup: texture memory, swirl address logic and output queue.
// A render item's texel is read into mem_q_reg on acceptance, then queued for output.
// Throughput: one item per cycle while in_stall is low; the single texture memory
// port serves one load or one render read per cycle, and a three-entry output
// queue absorbs stalls.
// Load items produce no result.
// Reset clears frozen, the output queue and the read pipeline; the texture
// memory is not cleared and holds nothing defined until loaded.
module swirl_texture_remap_top
    import stx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic [TICK_W-1:0]  tick,
    input  logic [COORD_W-1:0] col,
    input  logic [COORD_W-1:0] row,
    input  logic [TEXEL_W-1:0] texel_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [TEXEL_W-1:0] texel_out,
    output logic [INDEX_W-1:0] source_index
);

    logic frozen_reg;

    logic [TEXEL_W-1:0] texture_mem [TEXELS];
    logic [TEXEL_W-1:0] mem_q_reg;
    logic               rd_valid_reg;
    logic [INDEX_W-1:0] rd_index_reg;

    logic [TEXEL_W-1:0] q_texel_reg [QUEUE_DEPTH];
    logic [INDEX_W-1:0] q_index_reg [QUEUE_DEPTH];
    logic [1:0]         wr_ptr_reg, wr_ptr_next;
    logic [1:0]         rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;

    queue_status_t      status;
    logic               in_accept, render_accept, load_accept, push, pop;
    logic [TICK_W-1:0]  t;
    logic [PHASE_W-1:0] t13;
    logic [PHASE_W-1:0] kx1, kx2, ky1, ky2;
    logic [COORD_W-1:0] sx, sy;
    logic [INDEX_W-1:0] src_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frozen_reg <= 1'b0;
        else if (cfg_we)
            frozen_reg <= cfg_data;
    end

    assign status.count        = count_reg;
    assign status.read_pending = rd_valid_reg;

    // The queue must have room for everything already on its way.
    assign in_stall = ({1'b0, status.count} + {2'b00, status.read_pending}) >= 3'd3;

    assign in_accept     = in_valid && !in_stall;
    assign render_accept = in_accept && (mode == MODE_RENDER);
    assign load_accept   = in_accept && (mode == MODE_LOAD);

    // Swirl address; constant multiplies are shifts and adds, phases wrap at 13 bits.
    assign t   = frozen_reg ? '0 : tick;
    assign t13 = {5'b0, t};
    assign kx1 = {row, 7'b0} + (t13 << 7) + (t13 << 5) + SWIRL_X1;
    assign kx2 = {col[4:0], 8'b0} + (t13 << 7) + SWIRL_X2;
    assign ky1 = {col, 7'b0} + (t13 << 6) + (t13 << 5) + SWIRL_Y1;
    assign ky2 = {row[4:0], 8'b0} + (t13 << 7) + SWIRL_Y2;
    assign sx  = col + CENTER_BIAS + wave(kx1) + wave(kx2);
    assign sy  = row + CENTER_BIAS + wave(ky1) + wave(ky2);
    assign src_index = {sy, sx};

    always_ff @(posedge clk)
    begin
        if (load_accept)
            texture_mem[{row, col}] <= texel_in;
        if (render_accept)
            mem_q_reg <= texture_mem[src_index];
    end

    always_ff @(posedge clk)
    begin
        if (render_accept)
            rd_index_reg <= src_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_valid_reg <= 1'b0;
        else
            rd_valid_reg <= render_accept;
    end

    assign push = rd_valid_reg;
    assign pop  = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == 2'(QUEUE_DEPTH - 1)) ? 2'd0 : wr_ptr_reg + 2'd1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == 2'(QUEUE_DEPTH - 1)) ? 2'd0 : rd_ptr_reg + 2'd1;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_texel_reg[wr_ptr_reg] <= mem_q_reg;
            q_index_reg[wr_ptr_reg] <= rd_index_reg;
        end
    end

    assign out_valid    = count_reg != 2'd0;
    assign texel_out    = q_texel_reg[rd_ptr_reg];
    assign source_index = q_index_reg[rd_ptr_reg];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(QUEUE_DEPTH))
        else $error("output queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(count_reg == 2'(QUEUE_DEPTH) && rd_valid_reg))
        else $error("read arrives at a full output queue");

    a_render_reads: assert property (@(posedge clk) disable iff (!rst_n)
        render_accept |=> rd_valid_reg)
        else $error("render item did not start a memory read");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        load_accept |=> !rd_valid_reg)
        else $error("load item caused a memory read result");

endmodule
